// ===== design/ddk_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, arctangent table and helper functions for the
// differential-drive kinematics pipeline; no dependencies
package ddk_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ANG_TABLE_LEN    = 24;
  localparam int unsigned ZW               = 34;
  localparam int unsigned XW               = 33;

  localparam logic [15:0] RADIUS_RST = 16'd819;
  localparam logic [15:0] INVW_RST   = 16'd1280;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_INVW   = 1'b1;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] wheel_a;
    logic signed [15:0] wheel_b;
  } ddk_in_t;

  typedef struct packed {
    logic signed [31:0] dturn_dwheel;
    logic signed [31:0] dvely_dwheel;
    logic signed [31:0] dvelx_dwheel;
    logic signed [31:0] dvely_dheading;
    logic signed [31:0] dvelx_dheading;
    logic signed [31:0] turn_rate;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
  } ddk_out_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned k);
    int unsigned j;
    logic [31:0] v;
    j = (k < ANG_TABLE_LEN) ? k : ANG_TABLE_LEN - 1;
    unique case (j)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      default: v = 32'h0000007F;
    endcase
    return $signed({2'b00, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== design/diff_drive_kinematics_jacobian.sv =====
`timescale 1ns / 1ps
// top level of the differential-drive kinematics and jacobian pipeline
// depends on ddk_pkg, ddk_cordic, ddk_products
//
// usage: one word per sample enters on in_ (heading, wheel_a, wheel_b) and
// one word leaves on out_ with the state derivative and jacobian entries.
// the user must set radius and inverse track width through cfg_ only while
// the pipe is empty (not enforced by the block); they reset to 0.2 and 5.0.
// the pipe is a reduction stage, one stage per cordic step, a rounding
// stage, two multiply stages and a saturation stage. one word per cycle is
// accepted as long as the receiver takes results.
// the whole pipeline advances only while the last stage is empty or being
// taken; with out_tready low the pipe holds, and in_tready drops, only if
// the output stage is full.
// synchronous active-low reset empties all stages.
module diff_drive_kinematics_jacobian #(
  parameter int unsigned CORDIC_STEPS = ddk_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // heading, wheel_a, wheel_b
  output logic         out_tvalid,
  input  logic         out_tready,
  // vel_x, vel_y, turn_rate, dvelx_dheading, dvely_dheading,
  // dvelx_dwheel, dvely_dwheel, dturn_dwheel
  output logic [255:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import ddk_pkg::*;

  logic [15:0] radius_r, invw_r;
  logic        en, cv;
  ddk_in_t     item, citem;
  logic signed [16:0] c, s;
  ddk_out_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      invw_r   <= INVW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_wdata;
        CFG_INVW:   invw_r   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;
  assign item.heading = in_tdata[15:0];
  assign item.wheel_a = in_tdata[31:16];
  assign item.wheel_b = in_tdata[47:32];

  ddk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .item_i (item),
    .vld_o  (cv),
    .cos_o  (c),
    .sin_o  (s),
    .item_o (citem)
  );

  ddk_products u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (cv),
    .cos_i     (c),
    .sin_i     (s),
    .item_i    (citem),
    .radius    (radius_r),
    .inv_width (invw_r),
    .vld_o     (out_tvalid),
    .res_o     (res)
  );

  assign out_tdata = res;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result lost under stall");
  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[127:96] == -out_tdata[63:32]) ||
                   (out_tdata[63:32] == 32'h80000000))
    else $error("heading partial mismatch");
  a_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[159:128] == out_tdata[31:0])
    else $error("vel_x copy mismatch");
endmodule

// ===== design/ddk_cordic_stage.sv =====
`timescale 1ns / 1ps
// one rotation step of the sine/cosine cordic, registered, with stall
// depends on ddk_pkg
module ddk_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_i,
  input  logic signed [ddk_pkg::XW-1:0]    x_i,
  input  logic signed [ddk_pkg::XW-1:0]    y_i,
  input  logic signed [ddk_pkg::ZW-1:0]    z_i,
  input  logic                             flip_i,
  input  ddk_pkg::ddk_in_t                 item_i,
  output logic                             vld_o,
  output logic signed [ddk_pkg::XW-1:0]    x_o,
  output logic signed [ddk_pkg::XW-1:0]    y_o,
  output logic signed [ddk_pkg::ZW-1:0]    z_o,
  output logic                             flip_o,
  output ddk_pkg::ddk_in_t                 item_o
);
  import ddk_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_q30(STEP);

  logic signed [XW-1:0] x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_nxt;
  logic                 vld_r;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o    <= x_nxt;
      y_o    <= y_nxt;
      z_o    <= z_nxt;
      flip_o <= flip_i;
      item_o <= item_i;
    end
  end

  assign vld_o = vld_r;
endmodule

// ===== design/ddk_cordic.sv =====
`timescale 1ns / 1ps
// pipelined cordic: angle reduction stage, one stage per step, then a rounding stage
// depends on ddk_pkg, ddk_cordic_stage
module ddk_cordic #(
  parameter int unsigned CORDIC_STEPS = ddk_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  ddk_pkg::ddk_in_t      item_i,
  output logic                  vld_o,
  output logic signed [16:0]    cos_o,
  output logic signed [16:0]    sin_o,
  output ddk_pkg::ddk_in_t      item_o
);
  import ddk_pkg::*;

  logic                 vld_w  [CORDIC_STEPS+1];
  logic signed [XW-1:0] x_w    [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_w    [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_w    [CORDIC_STEPS+1];
  logic                 flip_w [CORDIC_STEPS+1];
  ddk_in_t              item_w [CORDIC_STEPS+1];

  logic signed [ZW-1:0] z0, z_nxt;
  logic                 flip_nxt, vld0_r;

  assign z0 = $signed({item_i.heading[15], item_i.heading, 17'd0});

  always_comb begin
    z_nxt    = z0;
    flip_nxt = 1'b0;
    if (z0 > HALF_PI_Q30) begin
      z_nxt    = z0 - PI_Q30;
      flip_nxt = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z_nxt    = z0 + PI_Q30;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_w[0]    <= z_nxt;
      flip_w[0] <= flip_nxt;
      item_w[0] <= item_i;
    end
  end

  assign vld_w[0] = vld0_r;
  assign x_w[0]   = GAIN_Q30;
  assign y_w[0]   = '0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    ddk_cordic_stage #(.STEP(g)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld_w[g]),
      .x_i    (x_w[g]),
      .y_i    (y_w[g]),
      .z_i    (z_w[g]),
      .flip_i (flip_w[g]),
      .item_i (item_w[g]),
      .vld_o  (vld_w[g+1]),
      .x_o    (x_w[g+1]),
      .y_o    (y_w[g+1]),
      .z_o    (z_w[g+1]),
      .flip_o (flip_w[g+1]),
      .item_o (item_w[g+1])
    );
  end

  logic signed [XW:0] xf, yf;
  logic signed [XW:0] xr, yr;
  logic signed [16:0] cos_r, sin_r;
  logic               vld_r;
  ddk_in_t            item_r;

  assign xf = flip_w[CORDIC_STEPS] ? -(XW+1)'(x_w[CORDIC_STEPS]) : (XW+1)'(x_w[CORDIC_STEPS]);
  assign yf = flip_w[CORDIC_STEPS] ? -(XW+1)'(y_w[CORDIC_STEPS]) : (XW+1)'(y_w[CORDIC_STEPS]);
  assign xr = (xf + (XW+1)'(16384)) >>> 15;
  assign yr = (yf + (XW+1)'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_w[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r  <= xr[16:0];
      sin_r  <= yr[16:0];
      item_r <= item_w[CORDIC_STEPS];
    end
  end

  assign vld_o  = vld_r;
  assign cos_o  = cos_r;
  assign sin_o  = sin_r;
  assign item_o = item_r;
endmodule

// ===== design/ddk_products.sv =====
`timescale 1ns / 1ps
// product stages: scale, trig multiply, round and saturate
// depends on ddk_pkg
module ddk_products (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic signed [16:0] cos_i,
  input  logic signed [16:0] sin_i,
  input  ddk_pkg::ddk_in_t   item_i,
  input  logic [15:0]        radius,
  input  logic [15:0]        inv_width,
  output logic               vld_o,
  output ddk_pkg::ddk_out_t  res_o
);
  import ddk_pkg::*;

  // stage a: radius times speed sum/diff, radius times trig and width
  logic signed [16:0] sum_w, dif_w;
  logic signed [33:0] rsum_nxt, rdif_nxt;
  logic signed [33:0] rc_nxt, rs_nxt;
  logic signed [32:0] riw_nxt;
  logic signed [33:0] rsum_r, rdif_r;
  logic signed [33:0] rc_r, rs_r;
  logic signed [32:0] riw_r;
  logic signed [16:0] ca_r, sa_r;
  logic [15:0]        iw_r;
  logic               vla_r;

  assign sum_w    = 17'(item_i.wheel_a) + 17'(item_i.wheel_b);
  assign dif_w    = 17'(item_i.wheel_a) - 17'(item_i.wheel_b);
  assign rsum_nxt = $signed({1'b0, radius}) * sum_w;
  assign rdif_nxt = $signed({1'b0, radius}) * dif_w;
  assign rc_nxt   = $signed({1'b0, radius}) * cos_i;
  assign rs_nxt   = $signed({1'b0, radius}) * sin_i;
  assign riw_nxt  = $signed({1'b0, 32'(radius) * 32'(inv_width)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vla_r <= 1'b0;
    end else if (en) begin
      vla_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsum_r <= rsum_nxt;
      rdif_r <= rdif_nxt;
      rc_r   <= rc_nxt;
      rs_r   <= rs_nxt;
      riw_r  <= riw_nxt;
      ca_r   <= cos_i;
      sa_r   <= sin_i;
      iw_r   <= inv_width;
    end
  end

  // stage b: second products
  logic signed [50:0] px_r, py_r, pw_r;
  logic signed [33:0] rcb_r, rsb_r;
  logic signed [32:0] riwb_r;
  logic               vlb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlb_r <= 1'b0;
    end else if (en) begin
      vlb_r <= vla_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= rsum_r * ca_r;
      py_r   <= rsum_r * sa_r;
      pw_r   <= rdif_r * $signed({1'b0, iw_r});
      rcb_r  <= rc_r;
      rsb_r  <= rs_r;
      riwb_r <= riw_r;
    end
  end

  // stage c: round and saturate
  logic signed [63:0] vx_w, vy_w, w_w, c_w, s_w, iw_w;
  logic signed [31:0] vx_s, vy_s;
  ddk_out_t           res_r;
  logic               vlc_r;

  assign vx_w = (64'(px_r) + 64'sd524288) >>> 20;
  assign vy_w = (64'(py_r) + 64'sd524288) >>> 20;
  assign w_w  = (64'(pw_r) + 64'sd4096) >>> 13;
  assign c_w  = (64'(rcb_r) + 64'sd2048) >>> 12;
  assign s_w  = (64'(rsb_r) + 64'sd2048) >>> 12;
  assign iw_w = (64'(riwb_r) + 64'sd16) >>> 5;
  assign vx_s = sat32(vx_w);
  assign vy_s = sat32(vy_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlc_r <= 1'b0;
    end else if (en) begin
      vlc_r <= vlb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.vel_x          <= vx_s;
      res_r.vel_y          <= vy_s;
      res_r.turn_rate      <= sat32(w_w);
      res_r.dvelx_dheading <= sat32(-64'(vy_s));
      res_r.dvely_dheading <= vx_s;
      res_r.dvelx_dwheel   <= sat32(c_w);
      res_r.dvely_dwheel   <= sat32(s_w);
      res_r.dturn_dwheel   <= sat32(iw_w);
    end
  end

  assign vld_o = vlc_r;
  assign res_o = res_r;
endmodule
